// ----- rtl/core/csrbi_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, command and rounding types for the boundary interpolation matvec core
// no dependencies

package csrbi_pkg;

   localparam int NODES    = 1024;
   localparam int COEFS    = 4096;
   localparam int MAX_ROW  = 16;

   localparam int NODE_W   = $clog2(NODES);
   localparam int COEF_AW  = $clog2(COEFS);
   localparam int CNT_W    = $clog2(COEFS + 1);
   localparam int ROW_W    = $clog2(NODES + 1);
   localparam int RS_DEPTH = NODES + 1;
   localparam int LEN_W    = $clog2(MAX_ROW + 1);
   localparam int VAL_W    = 32;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int ACC_W    = PROD_W + LEN_W;
   localparam int FRAC_W   = 30;
   localparam int RND_W    = ACC_W - FRAC_W;
   localparam int COEF_DW  = NODE_W + VAL_W;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;
   localparam logic [1:0] ST_SAT    = 2'd3;

   typedef enum logic [2:0] {
      OP_BEGIN     = 3'd0,
      OP_LOAD      = 3'd1,
      OP_FINISH    = 3'd2,
      OP_WRITE_X   = 3'd3,
      OP_FORWARD   = 3'd4,
      OP_TRANSPOSE = 3'd5,
      OP_RESIDUAL  = 3'd6
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [NODE_W-1:0]         node;
      logic [NODE_W-1:0]         column;
      logic signed [VAL_W-1:0]   weight;
      logic signed [VAL_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic              sat;
      logic [VAL_W-1:0]  value;
   } rnd_type;

   // round half up from the 30-bit fraction, then clip to 32 bits
   function automatic rnd_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] t;
      logic signed [RND_W-1:0] r;
      logic signed [RND_W-1:0] r_max;
      logic signed [RND_W-1:0] r_min;
      rnd_type res;
      t     = acc + (ACC_W'(1) <<< (FRAC_W - 1));
      r     = $signed(t[ACC_W-1:FRAC_W]);
      r_max = {{(RND_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
      r_min = {{(RND_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
      if (r > r_max) begin
         res.sat   = 1'b1;
         res.value = r_max[VAL_W-1:0];
      end else if (r < r_min) begin
         res.sat   = 1'b1;
         res.value = r_min[VAL_W-1:0];
      end else begin
         res.sat   = 1'b0;
         res.value = r[VAL_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/csrbi_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module csrbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/csrbi_front.sv -----
`timescale 1ns / 1ps
// front end: accepts request transactions, decodes the mode, queues commands
// depends on csrbi_pkg

module csrbi_front
   import csrbi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_mode,
   input  logic [NODE_W-1:0]       req_node,
   input  logic [NODE_W-1:0]       req_column,
   input  logic signed [VAL_W-1:0] req_weight,
   input  logic signed [VAL_W-1:0] req_value_in,
   output cmd_type                 cmd,
   output logic                    cmd_valid,
   input  logic                    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       known;
   logic       push;
   cmd_type    dec;

   always_comb begin
      known      = 1'b0;
      dec.op     = OP_BEGIN;
      dec.node   = req_node;
      dec.column = req_column;
      dec.weight = req_weight;
      dec.value  = req_value_in;
      unique case (req_mode)
         OP_BEGIN, OP_LOAD, OP_FINISH, OP_WRITE_X,
         OP_FORWARD, OP_TRANSPOSE, OP_RESIDUAL: begin
            known  = 1'b1;
            dec.op = op_type'(req_mode);
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && known;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ----- rtl/core/csrbi_back.sv -----
`timescale 1ns / 1ps
// back end: sequencer over the coefficient, row start and node value rams
// depends on csrbi_pkg and csrbi_ram

module csrbi_back
   import csrbi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic                    cmd_valid,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NODE_W-1:0]       rsp_index,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_FILL = 10'b0000000010,
      S_Q1   = 10'b0000000100,
      S_Q2   = 10'b0000001000,
      S_CRD  = 10'b0000010000,
      S_XRD  = 10'b0000100000,
      S_MUL  = 10'b0001000000,
      S_ACC  = 10'b0010000000,
      S_OUT  = 10'b0100000000,
      S_EMIT = 10'b1000000000
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [ROW_W-1:0]        next_row_ff, next_row_in;
   logic [CNT_W-1:0]        coef_count_ff, coef_count_in;
   logic [CNT_W-1:0]        cur_start_ff, cur_start_in;
   logic [ROW_W-1:0]        fill_to_ff, fill_to_in;
   logic                    fill_coef_ff, fill_coef_in;
   logic [CNT_W-1:0]        start_ff, start_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] xr_ff, xr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [NODE_W-1:0]       res_index_ff, res_index_in;
   logic [VAL_W-1:0]        res_value_ff, res_value_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic                    res_last_ff, res_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // ram ports
   logic                    coef_wr_en, coef_rd_en;
   logic [COEF_AW-1:0]      coef_wr_addr, coef_rd_addr;
   logic [COEF_DW-1:0]      coef_wr_data, coef_rd_data;
   logic                    rs_wr_en, rs_rd_en;
   logic [ROW_W-1:0]        rs_wr_addr, rs_rd_addr;
   logic [CNT_W-1:0]        rs_wr_data, rs_rd_data;
   logic                    x_wr_en, x_rd_en;
   logic [NODE_W-1:0]       x_wr_addr, x_rd_addr;
   logic [VAL_W-1:0]        x_wr_data, x_rd_data;

   logic [ROW_W-1:0]        node_ext, node_next;
   logic [ROW_W-1:0]        cnode_ext, cnode_next;
   logic                    bad;
   logic [CNT_W-1:0]        end_b, diff;
   logic signed [ACC_W-1:0] base, prod_ext;
   logic                    is_last;
   logic [NODE_W-1:0]       coef_col;
   logic signed [VAL_W-1:0] coef_w;
   logic signed [VAL_W-1:0] mul_b;
   rnd_type                 rnd;
   logic                    out_free;

   csrbi_ram #(.WIDTH(COEF_DW), .DEPTH(COEFS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (coef_wr_data),
      .rd_en   (coef_rd_en),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   csrbi_ram #(.WIDTH(CNT_W), .DEPTH(RS_DEPTH)) u_row_ram (
      .clock   (clock),
      .wr_en   (rs_wr_en),
      .wr_addr (rs_wr_addr),
      .wr_data (rs_wr_data),
      .rd_en   (rs_rd_en),
      .rd_addr (rs_rd_addr),
      .rd_data (rs_rd_data)
   );

   csrbi_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_x_ram (
      .clock   (clock),
      .wr_en   (x_wr_en),
      .wr_addr (x_wr_addr),
      .wr_data (x_wr_data),
      .rd_en   (x_rd_en),
      .rd_addr (x_rd_addr),
      .rd_data (x_rd_data)
   );

   assign coef_col   = coef_rd_data[COEF_DW-1:VAL_W];
   assign coef_w     = $signed(coef_rd_data[VAL_W-1:0]);
   assign node_ext   = {1'b0, cmd.node};
   assign node_next  = node_ext + ROW_W'(1);
   assign cnode_ext  = {1'b0, cmd_ff.node};
   assign cnode_next = cnode_ext + ROW_W'(1);
   assign prod_ext   = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign is_last    = ((idx_ff + LEN_W'(1)) == len_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mul_b      = (cmd_ff.op == OP_TRANSPOSE) ? xr_ff : $signed(x_rd_data);
   assign rnd        = round_sat((state_ff == S_ACC) ? -prod_ext : acc_ff);

   always_comb begin
      bad = (node_next < next_row_ff)
         || (coef_count_ff >= CNT_W'(COEFS))
         || ((node_next == next_row_ff)
             && ((coef_count_ff - cur_start_ff) >= CNT_W'(MAX_ROW)));
      end_b = (cnode_next < next_row_ff) ? rs_rd_data : coef_count_ff;
      diff  = (end_b > start_ff) ? (end_b - start_ff) : '0;
      if (cmd_ff.op == OP_FORWARD) begin
         base = {{(ACC_W-VAL_W){cmd_ff.value[VAL_W-1]}}, cmd_ff.value};
      end else begin
         base = -{{(ACC_W-VAL_W){xr_ff[VAL_W-1]}}, xr_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      next_row_in   = next_row_ff;
      coef_count_in = coef_count_ff;
      cur_start_in  = cur_start_ff;
      fill_to_in    = fill_to_ff;
      fill_coef_in  = fill_coef_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      xr_in         = xr_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      res_index_in  = res_index_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_pop       = 1'b0;
      coef_wr_en    = 1'b0;
      coef_wr_addr  = coef_count_ff[COEF_AW-1:0];
      coef_wr_data  = {cmd_ff.column, cmd_ff.weight};
      coef_rd_en    = 1'b0;
      coef_rd_addr  = COEF_AW'(start_ff + CNT_W'(idx_ff));
      rs_wr_en      = 1'b0;
      rs_wr_addr    = next_row_ff;
      rs_wr_data    = coef_count_ff;
      rs_rd_en      = 1'b0;
      rs_rd_addr    = node_ext;
      x_wr_en       = 1'b0;
      x_wr_addr     = cmd.node;
      x_wr_data     = cmd.value;
      x_rd_en       = 1'b0;
      x_rd_addr     = cmd.node;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               case (cmd.op)
                  OP_BEGIN: begin
                     next_row_in   = '0;
                     coef_count_in = '0;
                  end
                  OP_LOAD: begin
                     res_index_in = cmd.node;
                     res_value_in = '0;
                     res_last_in  = 1'b1;
                     if (bad) begin
                        res_status_in = ST_REJECT;
                        state_in      = S_EMIT;
                     end else begin
                        fill_to_in   = node_ext;
                        fill_coef_in = 1'b1;
                        state_in     = S_FILL;
                     end
                  end
                  OP_FINISH: begin
                     fill_to_in   = ROW_W'(NODES);
                     fill_coef_in = 1'b0;
                     state_in     = S_FILL;
                  end
                  OP_WRITE_X: begin
                     x_wr_en = 1'b1;
                  end
                  default: begin
                     rs_rd_en = 1'b1;
                     x_rd_en  = 1'b1;
                     state_in = S_Q1;
                  end
               endcase
            end
         end
         S_FILL: begin
            if (next_row_ff <= fill_to_ff) begin
               rs_wr_en     = 1'b1;
               cur_start_in = coef_count_ff;
               next_row_in  = next_row_ff + ROW_W'(1);
            end else if (fill_coef_ff) begin
               coef_wr_en    = 1'b1;
               coef_count_in = coef_count_ff + CNT_W'(1);
               res_status_in = ST_OK;
               state_in      = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_Q1: begin
            start_in   = (cnode_ext < next_row_ff) ? rs_rd_data : coef_count_ff;
            xr_in      = $signed(x_rd_data);
            rs_rd_en   = 1'b1;
            rs_rd_addr = cnode_next;
            state_in   = S_Q2;
         end
         S_Q2: begin
            if (diff > CNT_W'(MAX_ROW)) begin
               len_in = LEN_W'(MAX_ROW);
            end else begin
               len_in = diff[LEN_W-1:0];
            end
            idx_in = '0;
            acc_in = base <<< FRAC_W;
            if (diff == '0) begin
               res_index_in  = cmd_ff.node;
               res_value_in  = '0;
               res_status_in = ST_EMPTY;
               res_last_in   = 1'b1;
               state_in      = S_EMIT;
            end else begin
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            coef_rd_en = 1'b1;
            state_in   = S_XRD;
         end
         S_XRD: begin
            x_rd_en   = 1'b1;
            x_rd_addr = coef_col;
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_in  = coef_w * mul_b;
            state_in = S_ACC;
         end
         S_ACC: begin
            idx_in = idx_ff + LEN_W'(1);
            if (cmd_ff.op == OP_TRANSPOSE) begin
               res_index_in  = coef_col;
               res_value_in  = rnd.value;
               res_status_in = rnd.sat ? ST_SAT : ST_OK;
               res_last_in   = is_last;
               state_in      = S_EMIT;
            end else begin
               acc_in   = (cmd_ff.op == OP_FORWARD) ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
               state_in = is_last ? S_OUT : S_CRD;
            end
         end
         S_OUT: begin
            res_index_in  = cmd_ff.node;
            res_value_in  = rnd.value;
            res_status_in = rnd.sat ? ST_SAT : ST_OK;
            res_last_in   = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_last_in   = res_last_ff;
               state_in      = res_last_ff ? S_IDLE : S_CRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_row_ff   <= '0;
         coef_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_row_ff   <= next_row_in;
         coef_count_ff <= coef_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cur_start_ff  <= cur_start_in;
      fill_to_ff    <= fill_to_in;
      fill_coef_ff  <= fill_coef_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      xr_ff         <= xr_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      res_index_ff  <= res_index_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_value_out = $signed(rsp_value_ff);
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/core/csr_boundary_interpolation_matvec_core.sv -----
`timescale 1ns / 1ps
// compressed-row boundary interpolation matvec core: top level
// depends on csrbi_pkg, csrbi_front, csrbi_back
// flow: requests pass the front queue, then forward/residual walk each stored coef of the row (up to 16),
//   transpose emits one delta per coef, load fills skipped row starts then writes its coef, finish fills the rest
// back end: one request at a time, set by the ram walk per coef through the single-read rams
// reset: synchronous, clears load counters, queue and output valid; rams keep contents

module csr_boundary_interpolation_matvec_core
   import csrbi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_mode,
   input  logic [NODE_W-1:0]       req_node,
   input  logic [NODE_W-1:0]       req_column,
   input  logic signed [VAL_W-1:0] req_weight,
   input  logic signed [VAL_W-1:0] req_value_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NODE_W-1:0]       rsp_index,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   // decoded command handed from the front queue to the sequencer
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // front: takes each request transaction, drops unused mode codes, two-deep queue
   csrbi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_node     (req_node),
      .req_column   (req_column),
      .req_weight   (req_weight),
      .req_value_in (req_value_in),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop)
   );

   // back: row pointer builder, coefficient walk with one multiplier, output register
   csrbi_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_index     (rsp_index),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule
